FILE: hw/rtl/mbed_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
package mbed_pkg;
  localparam int Window = 16;
  localparam int RingDepth = 128;
  localparam int RingAw = 7;
  localparam int ReadyLevel = 50;

  localparam logic [1:0] CfgThreshold = 2'd0;
  localparam logic [1:0] CfgBlend = 2'd1;
  localparam logic [1:0] CfgLimit = 2'd2;

  localparam logic [1:0] PhaseIdle = 2'd0;
  localparam logic [1:0] PhaseEvent = 2'd1;
  localparam logic [1:0] PhaseEnded = 2'd2;

  typedef struct packed {
    logic       ready_res;
    logic [1:0] event_phase;
    logic signed [15:0] baseline_x;
    logic signed [15:0] baseline_y;
    logic signed [15:0] baseline_z;
    logic [6:0] records_logged;
  } out_item_t;

  typedef struct packed {
    logic mode;
    logic signed [15:0] sample_x;
    logic signed [15:0] sample_y;
    logic signed [15:0] sample_z;
  } in_item_t;

  typedef struct packed {
    logic [1:0]  index;
    logic [15:0] data;
  } cfg_item_t;

  // divider handshake between top level and divider unit
  typedef struct packed {
    logic        start;
    logic signed [23:0] dividend;
    logic [7:0]  divisor;
  } div_req_t;

  typedef enum logic [3:0] {
    ST_IDLE, ST_WRITE, ST_WSUM, ST_WDIV, ST_HSUM, ST_HDIV,
    ST_TRACK, ST_BLEND, ST_AXNEXT, ST_OUT
  } state_t;
endpackage
`default_nettype wire

FILE: hw/rtl/mbed_if.sv
`timescale 1ns / 1ps
`default_nettype none
interface mbed_in_if;
  logic valid;
  logic ready;
  mbed_pkg::in_item_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface mbed_out_if;
  logic valid;
  logic ready;
  mbed_pkg::out_item_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface mbed_cfg_if;
  logic valid;
  logic ready;
  mbed_pkg::cfg_item_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface
`default_nettype wire

FILE: hw/rtl/mbed_ram.sv
`timescale 1ns / 1ps
`default_nettype none
module mbed_ram #(
  parameter int Width = 16,
  parameter int Depth = 384
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(Depth)-1:0] waddr,
  input  wire logic [Width-1:0]         wdata,
  input  wire logic [$clog2(Depth)-1:0] raddr,
  output logic      [Width-1:0]         rdata
);
  logic [Width-1:0] mem [Depth];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule
`default_nettype wire

FILE: hw/rtl/mbed_div.sv
`timescale 1ns / 1ps
`default_nettype none
module mbed_div (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire mbed_pkg::div_req_t req,
  output logic                    busy,
  output logic signed [15:0]      quot
);
  import mbed_pkg::*;

  logic [4:0]  cnt_r, cnt_nxt;
  logic [23:0] q_r, q_nxt;
  logic [8:0]  rem_r, rem_nxt;
  logic [7:0]  dvs_r, dvs_nxt;
  logic        neg_r, neg_nxt;
  logic [9:0]  trial;
  logic [23:0] qneg;

  // restoring division, one quotient bit a cycle, truncates toward zero
  always_comb begin
    cnt_nxt = cnt_r;
    q_nxt = q_r;
    rem_nxt = rem_r;
    dvs_nxt = dvs_r;
    neg_nxt = neg_r;
    trial = '0;
    if (req.start) begin
      neg_nxt = req.dividend[23];
      q_nxt = req.dividend[23] ? (~req.dividend + 24'd1) : req.dividend;
      rem_nxt = '0;
      dvs_nxt = req.divisor;
      cnt_nxt = 5'd24;
    end else if (cnt_r != 5'd0) begin
      trial = {rem_r, q_r[23]} - {2'b00, dvs_r};
      if (!trial[9]) begin
        rem_nxt = trial[8:0];
        q_nxt = {q_r[22:0], 1'b1};
      end else begin
        rem_nxt = {rem_r[7:0], q_r[23]};
        q_nxt = {q_r[22:0], 1'b0};
      end
      cnt_nxt = cnt_r - 5'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else begin
      cnt_r <= cnt_nxt;
    end
    q_r <= q_nxt;
    rem_r <= rem_nxt;
    dvs_r <= dvs_nxt;
    neg_r <= neg_nxt;
  end

  assign qneg = ~q_r + 24'd1;
  assign busy = (cnt_r != 5'd0);
  assign quot = neg_r ? qneg[15:0] : q_r[15:0];
endmodule
`default_nettype wire

FILE: hw/rtl/magnetic_baseline_event_detector_core.sv
`timescale 1ns / 1ps
`default_nettype none
// magnetometer baseline tracker and event detector
// in_*  : one item is one three-axis sample plus the mode bit (0 init, 1 track)
// out_* : one item per input item: ready flag, event phase, baselines and
//         the peak/valley log write index
// cfg_* : register writes (threshold, blend weight, count limit), taken at
//         any time, meant to be written while the block is idle
// one sequencer runs an item: it stores the samples, then per axis takes a
// window sum over n = min(count, 16) ring entries and a serial divide; init
// mode adds per axis a history sum over count stored averages and a second
// divide; track mode then updates each axis; an output step registers the
// result; the next item is taken once the block is back in idle, and the
// one read port per memory and the single divider keep it from taking a new
// item before the current one is through
// the result waits in an output register while the next item is taken; a
// stalled receiver holds the block in its output step
// reset clears counters, baselines, phase and time; the memories need no
// clearing since only entries written since the last ring wrap are read
module magnetic_baseline_event_detector_core (
  input wire logic clk,
  input wire logic rst_n,
  mbed_in_if.sink    in_ch,
  mbed_out_if.source out_ch,
  mbed_cfg_if.sink   cfg_ch
);
  import mbed_pkg::*;

  // configuration
  logic [15:0] thr_r;
  logic [7:0]  alpha_r, limit_r;

  assign cfg_ch.ready = 1'b1;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      thr_r <= 16'd200;
      alpha_r <= 8'd26;
      limit_r <= 8'd10;
    end else if (cfg_ch.valid) begin
      unique case (cfg_ch.data.index)
        CfgThreshold: thr_r <= cfg_ch.data.data;
        CfgBlend:     alpha_r <= cfg_ch.data.data[7:0];
        CfgLimit:     limit_r <= cfg_ch.data.data[7:0];
        default: ;
      endcase
    end
  end

  state_t st_r, st_nxt;
  logic [1:0] ax_r, ax_nxt;
  logic [7:0] ri_r, ri_nxt;       // count of entries incl current (cnt)
  logic [7:0] k_r, k_nxt;          // read pointer
  logic       rdv_r, rdv_nxt;      // read data valid next cycle
  logic signed [23:0] acc_r, acc_nxt;
  logic       mode_r, mode_nxt;
  logic signed [15:0] smp_r [3];
  logic signed [15:0] smp_nxt [3];
  logic signed [15:0] bn_r [3];
  logic signed [15:0] bn_nxt [3];
  logic signed [15:0] bp_r [3];
  logic signed [15:0] bp_nxt [3];
  logic signed [15:0] avg_r, avg_nxt;
  logic [7:0] sc_r, sc_nxt, ec_r, ec_nxt;
  logic [1:0] ph_r, ph_nxt;
  logic [31:0] tick_r, tick_nxt, tst_r, tst_nxt, tend_r, tend_nxt;
  logic [6:0] li_r, li_nxt;
  logic signed [24:0] mix_r, mix_nxt;
  logic       ov_r, ov_nxt;
  out_item_t  od_r, od_nxt;
  logic       busy_wait_r, busy_wait_nxt;

  // memories, addressed by axis and entry
  logic        sr_we, ah_we, lg_we;
  logic [8:0]  sr_wa, sr_ra, ah_wa, ah_ra, lg_wa;
  logic [15:0] sr_wd, sr_rd, ah_wd, ah_rd, lv_wd, lv_rd;
  logic [31:0] lt_rd;
  logic [8:0]  lg_ra;

  mbed_ram #(.Width(16), .Depth(384)) u_ring (
    .clk, .we(sr_we), .waddr(sr_wa), .wdata(sr_wd), .raddr(sr_ra), .rdata(sr_rd));
  mbed_ram #(.Width(16), .Depth(384)) u_hist (
    .clk, .we(ah_we), .waddr(ah_wa), .wdata(ah_wd), .raddr(ah_ra), .rdata(ah_rd));
  mbed_ram #(.Width(16), .Depth(384)) u_logv (
    .clk, .we(lg_we), .waddr(lg_wa), .wdata(lv_wd), .raddr(lg_ra), .rdata(lv_rd));
  mbed_ram #(.Width(32), .Depth(384)) u_logt (
    .clk, .we(lg_we), .waddr(lg_wa), .wdata(tick_r), .raddr(lg_ra), .rdata(lt_rd));
  assign lg_ra = lg_wa;

  div_req_t dreq;
  logic dbusy;
  logic signed [15:0] dq;
  mbed_div u_div (.clk, .rst_n, .req(dreq), .busy(dbusy), .quot(dq));

  function automatic logic [8:0] addr_of(input logic [1:0] ax, input logic [6:0] e);
    addr_of = {ax, e};
  endfunction

  logic [7:0] first_w, nwin;
  logic [15:0] dev;
  logic signed [16:0] dsub;
  logic signed [15:0] s_cur;
  logic [7:0] sc_inc, ec_inc;
  logic signed [24:0] mixr;

  assign in_ch.ready = (st_r == ST_IDLE);
  assign out_ch.valid = ov_r;
  assign out_ch.data = od_r;

  always_comb begin
    st_nxt = st_r; ax_nxt = ax_r; ri_nxt = ri_r; k_nxt = k_r; rdv_nxt = 1'b0;
    acc_nxt = acc_r; mode_nxt = mode_r; avg_nxt = avg_r;
    smp_nxt = smp_r; bn_nxt = bn_r; bp_nxt = bp_r;
    sc_nxt = sc_r; ec_nxt = ec_r; ph_nxt = ph_r;
    tick_nxt = tick_r; tst_nxt = tst_r; tend_nxt = tend_r; li_nxt = li_r;
    mix_nxt = mix_r; ov_nxt = ov_r; od_nxt = od_r; busy_wait_nxt = 1'b0;
    sr_we = 1'b0; sr_wa = addr_of(ax_r, 7'(ri_r - 8'd1)); sr_wd = smp_r[ax_r];
    sr_ra = addr_of(ax_r, k_r[6:0]);
    ah_we = 1'b0; ah_wa = addr_of(ax_r, 7'(ri_r - 8'd1)); ah_wd = dq;
    ah_ra = addr_of(ax_r, k_r[6:0]);
    lg_we = 1'b0; lg_wa = addr_of(ax_r, li_r); lv_wd = smp_r[ax_r];
    dreq = '0;
    first_w = (ri_r < 8'(Window)) ? 8'd0 : ri_r - 8'(Window);
    nwin = ri_r - first_w;
    s_cur = smp_r[ax_r];
    dsub = 17'(bn_r[ax_r]) - 17'(s_cur);
    dev = dsub[16] ? 16'(-dsub) : dsub[15:0];
    sc_inc = sc_r + 8'd1;
    ec_inc = ec_r + 8'd1;
    mixr = mix_r + 25'sd128;

    if (out_ch.ready && ov_r) ov_nxt = 1'b0;

    unique case (st_r)
      ST_IDLE: begin
        if (in_ch.valid) begin
          mode_nxt = in_ch.data.mode;
          smp_nxt[0] = in_ch.data.sample_x;
          smp_nxt[1] = in_ch.data.sample_y;
          smp_nxt[2] = in_ch.data.sample_z;
          tick_nxt = tick_r + 32'd1;
          ri_nxt = (ri_r >= 8'(RingDepth)) ? 8'd1 : ri_r + 8'd1;
          ax_nxt = 2'd0;
          st_nxt = ST_WRITE;
        end
      end
      ST_WRITE: begin
        // store the three samples, one axis a cycle
        sr_we = 1'b1;
        if (ax_r == 2'd2) begin
          ax_nxt = 2'd0; k_nxt = first_w; acc_nxt = '0; st_nxt = ST_WSUM;
        end else ax_nxt = ax_r + 2'd1;
      end
      ST_WSUM: begin
        // window sum over the ring
        if (rdv_r) acc_nxt = acc_r + 24'($signed(sr_rd));
        if (k_r < ri_r) begin
          k_nxt = k_r + 8'd1; rdv_nxt = 1'b1;
        end else if (!rdv_r) begin
          dreq.start = 1'b1; dreq.dividend = acc_r; dreq.divisor = nwin;
          busy_wait_nxt = 1'b1; st_nxt = ST_WDIV;
        end
      end
      ST_WDIV: begin
        if (!busy_wait_r && !dbusy) begin
          ah_we = 1'b1; avg_nxt = dq;
          if (ax_r == 2'd2) begin
            ax_nxt = 2'd0;
            k_nxt = 8'd0; acc_nxt = '0;
            st_nxt = mode_r ? ST_TRACK : ST_HSUM;
          end else begin
            ax_nxt = ax_r + 2'd1; k_nxt = first_w; acc_nxt = '0; st_nxt = ST_WSUM;
          end
        end
      end
      ST_HSUM: begin
        // mean of stored averages
        if (rdv_r) acc_nxt = acc_r + 24'($signed(ah_rd));
        if (k_r < ri_r) begin
          k_nxt = k_r + 8'd1; rdv_nxt = 1'b1;
        end else if (!rdv_r) begin
          dreq.start = 1'b1; dreq.dividend = acc_r; dreq.divisor = ri_r;
          busy_wait_nxt = 1'b1; st_nxt = ST_HDIV;
        end
      end
      ST_HDIV: begin
        if (!busy_wait_r && !dbusy) begin
          bn_nxt[ax_r] = dq; bp_nxt[ax_r] = dq;
          if (ax_r == 2'd2) st_nxt = ST_OUT;
          else begin
            ax_nxt = ax_r + 2'd1; k_nxt = 8'd0; acc_nxt = '0; st_nxt = ST_HSUM;
          end
        end
      end
      ST_TRACK: begin
        // read the latest average for this axis
        k_nxt = ri_r - 8'd1; rdv_nxt = 1'b1;
        if (rdv_r) begin
          rdv_nxt = 1'b0;
          if (dev >= thr_r) begin
            bn_nxt[ax_r] = bp_r[ax_r]; bp_nxt[ax_r] = bn_r[ax_r];
            sc_nxt = sc_inc;
            if (sc_inc >= limit_r) begin
              if (bp_r[ax_r] <= s_cur || ph_r == PhaseEvent) begin
                sc_nxt = 8'd0; lg_we = 1'b1;
                li_nxt = (li_r == 7'(RingDepth - 1)) ? 7'd0 : li_r + 7'd1;
              end
              if (ph_r != PhaseEvent) begin
                tst_nxt = tick_r; ph_nxt = PhaseEvent;
              end
            end
            st_nxt = ST_AXNEXT;
          end else begin
            mix_nxt = 25'(bp_r[ax_r]) * 25'($signed({1'b0, 9'd256 - {1'b0, alpha_r}}))
                    + 25'($signed(ah_rd)) * 25'($signed({1'b0, alpha_r}));
            st_nxt = ST_BLEND;
          end
        end
      end
      ST_BLEND: begin
        if (sc_r == 8'd0 && ph_r != PhaseEvent) begin
          ph_nxt = PhaseIdle;
          bp_nxt[ax_r] = bn_r[ax_r];
          bn_nxt[ax_r] = mixr[23:8];
        end else if (ph_r == PhaseEvent) begin
          ec_nxt = ec_inc;
          if (ec_inc >= limit_r) begin
            tend_nxt = tick_r; ph_nxt = PhaseEnded; ec_nxt = 8'd0;
          end
        end
        st_nxt = ST_AXNEXT;
      end
      ST_AXNEXT: begin
        if (ax_r == 2'd2) st_nxt = ST_OUT;
        else begin ax_nxt = ax_r + 2'd1; st_nxt = ST_TRACK; end
      end
      ST_OUT: begin
        // wait here while the previous result is still held
        if (!ov_r || out_ch.ready) begin
          od_nxt.ready_res = (ri_r >= 8'(ReadyLevel)) && (ri_r < 8'(RingDepth));
          od_nxt.event_phase = ph_r;
          od_nxt.baseline_x = bn_r[0];
          od_nxt.baseline_y = bn_r[1];
          od_nxt.baseline_z = bn_r[2];
          od_nxt.records_logged = li_r;
          ov_nxt = 1'b1;
          st_nxt = ST_IDLE;
        end
      end
      default: st_nxt = ST_IDLE;
    endcase
    if (st_r == ST_TRACK) ah_ra = addr_of(ax_r, 7'(ri_r - 8'd1));
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= ST_IDLE; ax_r <= '0; ri_r <= '0; k_r <= '0; rdv_r <= 1'b0;
      for (int i = 0; i < 3; i++) begin bn_r[i] <= '0; bp_r[i] <= '0; end
      sc_r <= '0; ec_r <= '0; ph_r <= PhaseIdle;
      tick_r <= '0; tst_r <= '0; tend_r <= '0; li_r <= '0;
      ov_r <= 1'b0; busy_wait_r <= 1'b0;
    end else begin
      st_r <= st_nxt; ax_r <= ax_nxt; ri_r <= ri_nxt; k_r <= k_nxt; rdv_r <= rdv_nxt;
      bn_r <= bn_nxt; bp_r <= bp_nxt;
      sc_r <= sc_nxt; ec_r <= ec_nxt; ph_r <= ph_nxt;
      tick_r <= tick_nxt; tst_r <= tst_nxt; tend_r <= tend_nxt; li_r <= li_nxt;
      ov_r <= ov_nxt; busy_wait_r <= busy_wait_nxt;
    end
    acc_r <= acc_nxt; mode_r <= mode_nxt; smp_r <= smp_nxt; avg_r <= avg_nxt;
    mix_r <= mix_nxt; od_r <= od_nxt;
  end

  logic unused_ok;
  assign unused_ok = ^{lv_rd, lt_rd, tst_r, tend_r, avg_r};
endmodule
`default_nettype wire
